@@ src/fnrzi_pkg.sv @@
// Shared types and constants for the framed 4B5B / NRZI encoder.
package fnrzi_pkg;

  localparam int CODE_W     = 5;
  localparam int CODES_PER  = 5;
  localparam int TAB_N      = 17;
  localparam int SYNC_IDX   = 16;
  localparam int WIDE_REG_W = CODE_W * CODES_PER;
  localparam int TAIL_REG_W = 2 * CODE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int LEVEL_W    = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int BIT_CNT_W  = 3;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_SYM = BIT_CNT_W'(CODE_W);

  localparam logic [WIDE_REG_W-1:0] RST_CODES_0_4   = 25'd11194686;
  localparam logic [WIDE_REG_W-1:0] RST_CODES_5_9   = 25'd20528587;
  localparam logic [WIDE_REG_W-1:0] RST_CODES_10_14 = 25'd30272246;
  localparam logic [TAIL_REG_W-1:0] RST_CODES_15_SY = 10'd1021;

  localparam logic [LEVEL_W-1:0] LEVEL_SILENCE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODES_0_4   = 3'd0,
    CFG_CODES_5_9   = 3'd1,
    CFG_CODES_10_14 = 3'd2,
    CFG_CODES_15_SY = 3'd3
  } cfg_reg_t;

  // Symbol slots of one data byte, in line order.
  typedef enum logic [2:0] {
    STEP_PREAMBLE  = 3'd0,
    STEP_SYNC_HEAD = 3'd1,
    STEP_HIGH      = 3'd2,
    STEP_LOW       = 3'd3,
    STEP_TRAIL     = 3'd4,
    STEP_SYNC_TAIL = 3'd5
  } step_t;

  // One queued symbol: what the serializer needs to put it on the line.
  typedef struct packed {
    logic              silence;
    logic              set_low;
    logic              last;
    logic [CODE_W-1:0] code;
  } sym_t;

endpackage

@@ src/fnrzi_front.sv @@
// Front end: config code table, item intake and symbol generation.
module fnrzi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fnrzi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fnrzi_pkg::WIDE_REG_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [fnrzi_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                                in_first_of_packet,
  input  logic                                in_last_of_packet,
  output logic                                sym_valid,
  input  logic                                sym_ready,
  output fnrzi_pkg::sym_t                     sym_data
);

  logic [fnrzi_pkg::WIDE_REG_W-1:0] codes_0_4_r, codes_5_9_r, codes_10_14_r;
  logic [fnrzi_pkg::TAIL_REG_W-1:0] codes_15_sy_r;
  logic [fnrzi_pkg::CODE_W-1:0]     code_tab [fnrzi_pkg::TAB_N];

  logic                         busy_r, busy_nxt;
  logic                         idle_r;
  logic [fnrzi_pkg::BYTE_W-1:0] byte_r;
  fnrzi_pkg::step_t             step_r, step_nxt, end_r;

  logic accept, push, done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_0_4_r   <= fnrzi_pkg::RST_CODES_0_4;
      codes_5_9_r   <= fnrzi_pkg::RST_CODES_5_9;
      codes_10_14_r <= fnrzi_pkg::RST_CODES_10_14;
      codes_15_sy_r <= fnrzi_pkg::RST_CODES_15_SY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fnrzi_pkg::CFG_CODES_0_4:   codes_0_4_r   <= cfg_data;
        fnrzi_pkg::CFG_CODES_5_9:   codes_5_9_r   <= cfg_data;
        fnrzi_pkg::CFG_CODES_10_14: codes_10_14_r <= cfg_data;
        fnrzi_pkg::CFG_CODES_15_SY: codes_15_sy_r <= cfg_data[fnrzi_pkg::TAIL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < fnrzi_pkg::CODES_PER; k++) begin
      code_tab[k]      = codes_0_4_r[k*fnrzi_pkg::CODE_W +: fnrzi_pkg::CODE_W];
      code_tab[k + 5]  = codes_5_9_r[k*fnrzi_pkg::CODE_W +: fnrzi_pkg::CODE_W];
      code_tab[k + 10] = codes_10_14_r[k*fnrzi_pkg::CODE_W +: fnrzi_pkg::CODE_W];
    end
    code_tab[15] = codes_15_sy_r[fnrzi_pkg::CODE_W-1:0];
    code_tab[16] = codes_15_sy_r[fnrzi_pkg::TAIL_REG_W-1:fnrzi_pkg::CODE_W];
  end

  assign push     = busy_r & sym_ready;
  assign done     = push & (idle_r | (step_r == end_r));
  assign in_ready = ~busy_r | done;
  assign accept   = in_valid & in_ready;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = in_first_of_packet ? fnrzi_pkg::STEP_PREAMBLE : fnrzi_pkg::STEP_HIGH;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (push) begin
      step_nxt = fnrzi_pkg::step_t'(step_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= fnrzi_pkg::STEP_HIGH;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idle_r <= in_opcode;
      byte_r <= in_data_byte;
      end_r  <= in_last_of_packet ? fnrzi_pkg::STEP_SYNC_TAIL : fnrzi_pkg::STEP_LOW;
    end
  end

  always_comb begin
    sym_data.silence = idle_r;
    sym_data.set_low = 1'b0;
    sym_data.last    = idle_r | (step_r == end_r);
    unique case (step_r)
      fnrzi_pkg::STEP_PREAMBLE: begin
        sym_data.code    = '0;
        sym_data.set_low = 1'b1;
      end
      fnrzi_pkg::STEP_SYNC_HEAD: sym_data.code = code_tab[fnrzi_pkg::SYNC_IDX];
      fnrzi_pkg::STEP_HIGH:      sym_data.code = code_tab[{1'b0, byte_r[7:4]}];
      fnrzi_pkg::STEP_LOW:       sym_data.code = code_tab[{1'b0, byte_r[3:0]}];
      fnrzi_pkg::STEP_TRAIL:     sym_data.code = code_tab[0];
      fnrzi_pkg::STEP_SYNC_TAIL: sym_data.code = code_tab[fnrzi_pkg::SYNC_IDX];
      default:                   sym_data.code = '0;
    endcase
  end

  assign sym_valid = busy_r;

endmodule

@@ src/fnrzi_fifo.sv @@
// Short symbol queue between the front end and the serializer.
module fnrzi_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  fnrzi_pkg::sym_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output fnrzi_pkg::sym_t rd_data
);

  fnrzi_pkg::sym_t                   mem_r [fnrzi_pkg::FIFO_DEPTH];
  logic [fnrzi_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [fnrzi_pkg::FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                              wr_en, rd_en;

  assign wr_ready = (cnt_r != fnrzi_pkg::FIFO_CNT_W'(fnrzi_pkg::FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid & wr_ready;
  assign rd_en    = rd_valid & rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ src/fnrzi_back.sv @@
// Serializer: shifts symbols out MSB first through NRZI into the output register.
module fnrzi_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sym_valid,
  output logic                          sym_ready,
  input  fnrzi_pkg::sym_t               sym_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fnrzi_pkg::LEVEL_W-1:0] out_line_level,
  output logic                          out_last_of_run
);

  logic                               busy_r, busy_nxt;
  logic [fnrzi_pkg::CODE_W-1:0]       shift_r;
  logic [fnrzi_pkg::BIT_CNT_W-1:0]    cnt_r;
  logic                               sil_r, set_low_r, last_r;
  logic                               level_r;
  logic                               out_valid_r;
  logic [fnrzi_pkg::LEVEL_W-1:0]      out_level_r;
  logic                               out_last_r;

  logic adv, load, final_bit, base_level, bit_level;

  assign adv       = busy_r & (~out_valid_r | out_ready);
  assign final_bit = (cnt_r == 3'd1);
  assign sym_ready = ~busy_r | (adv & final_bit);
  assign load      = sym_valid & sym_ready;

  // preamble forces the level low before its first bit
  assign base_level = (set_low_r && cnt_r == fnrzi_pkg::BITS_PER_SYM) ? 1'b0 : level_r;
  assign bit_level  = base_level ^ shift_r[fnrzi_pkg::CODE_W-1];

  always_comb begin
    busy_nxt = busy_r;
    if (load) busy_nxt = 1'b1;
    else if (adv && final_bit) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (load) cnt_r <= sym_data.silence ? 3'd1 : fnrzi_pkg::BITS_PER_SYM;
      else if (adv) cnt_r <= cnt_r - 1'b1;
      if (adv && !sil_r) level_r <= bit_level;
      if (adv) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_r   <= sym_data.code;
      sil_r     <= sym_data.silence;
      set_low_r <= sym_data.set_low;
      last_r    <= sym_data.last;
    end else if (adv) begin
      shift_r <= {shift_r[fnrzi_pkg::CODE_W-2:0], 1'b0};
    end
    if (adv) begin
      out_level_r <= sil_r ? fnrzi_pkg::LEVEL_SILENCE : {1'b0, bit_level};
      out_last_r  <= last_r & final_bit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_level  = out_level_r;
  assign out_last_of_run = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0) && (cnt_r <= fnrzi_pkg::BITS_PER_SYM))
    else $error("bit count out of range while busy");

  a_silence_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && sil_r) |-> (cnt_r == 3'd1))
    else $error("silence symbol spans more than one beat");

  a_silence_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_level_r == fnrzi_pkg::LEVEL_SILENCE) |-> out_last_r)
    else $error("silence beat not marked last");

endmodule

@@ src/framed_4b5b_nrzi_encoder.sv @@
// An accepted item is registered in the front end; its symbols pass through the queue
// and the serializer shift register into the output register. The single serializer
// bit per cycle, held while out_ready is low, sets the rate; intake runs ahead via a
// 4-deep queue.
// Reset: synchronous active-low; restores the default FDDI code table, clears
// the queue and sets the internal NRZI level low.
module framed_4b5b_nrzi_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fnrzi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fnrzi_pkg::WIDE_REG_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [fnrzi_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                             in_first_of_packet,
  input  logic                             in_last_of_packet,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fnrzi_pkg::LEVEL_W-1:0]    out_line_level,
  output logic                             out_last_of_run
);

  logic            f2q_valid, f2q_ready, q2b_valid, q2b_ready;
  fnrzi_pkg::sym_t f2q_data, q2b_data;

  fnrzi_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_first_of_packet (in_first_of_packet),
    .in_last_of_packet  (in_last_of_packet),
    .sym_valid          (f2q_valid),
    .sym_ready          (f2q_ready),
    .sym_data           (f2q_data)
  );

  fnrzi_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f2q_valid),
    .wr_ready (f2q_ready),
    .wr_data  (f2q_data),
    .rd_valid (q2b_valid),
    .rd_ready (q2b_ready),
    .rd_data  (q2b_data)
  );

  fnrzi_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .sym_valid       (q2b_valid),
    .sym_ready       (q2b_ready),
    .sym_data        (q2b_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_level  (out_line_level),
    .out_last_of_run (out_last_of_run)
  );

endmodule
